// ===== sv/bawc_pkg.sv =====
// bawc_pkg: shared widths, register codes and the result entry type
// for the bit aligned word copy unit and its checker
// no dependencies
`timescale 1ns / 1ps

package bawc_pkg;

	// port widths
	localparam int DATA_W            = 64;
	localparam int WIDTH_W           = 32;
	localparam int OFF_W             = 6;
	localparam int IDX_W             = 27;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 32;
	localparam int WORD_BITS_DEFAULT = 64;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COPY_WIDTH = 2'd0,
		REG_SRC_OFFSET = 2'd1,
		REG_DST_OFFSET = 2'd2
	} cfg_reg_t;

	// one destination word as it waits in the output queue
	typedef struct packed {
		logic [DATA_W-1:0] word;
		logic [DATA_W-1:0] mask;
		logic [IDX_W-1:0]  index;
		logic              last;
	} result_t;

endpackage

// ===== sv/bit_aligned_word_copy_unit.sv =====
// bit_aligned_word_copy_unit: repacks a bit run from a source word stream
// into masked destination words
// depends on bawc_pkg
`timescale 1ns / 1ps

// Usage
// Program copy_width, src_bit_offset and dst_bit_offset on the cfg channel
// (cfg_ready is always high) while the unit is idle; a write to one of them
// restarts the copy. Then send source words on src_valid/src_word. Each
// destination word leaves on dst_valid with dst_word, write_mask and
// dst_index (relative to the first destination word); memory merges only
// the masked bits. last_of_copy marks the final word, after which the unit
// is ready for the same copy again. With copy_width zero a source word is
// taken and dropped.
// A source word is held in the input register until the output queue has room
// for its results, which are then written to the output queue; the queue head
// drives the destination port.
// Throughput: one source word per cycle and one result per cycle while
// neither src_stall nor dst_stall holds the flow; the output port moves one
// word a cycle, so a copy end that flushes two words queues one extra word.
// src_stall rises when a word waits in the input register while the
// four-entry output queue holds more than two words, either because
// dst_stall has held results back or several two-word steps came in a row.
// Reset clears the registers to zero, the copy state, the input register and
// the output queue.

module bit_aligned_word_copy_unit #(
	parameter int WORD_BITS = bawc_pkg::WORD_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bawc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bawc_pkg::CFG_DATA_W-1:0]  cfg_data,
	// source words
	input  logic                             src_valid,
	output logic                             src_stall,
	input  logic [bawc_pkg::DATA_W-1:0]      src_word,
	// destination words
	output logic                             dst_valid,
	input  logic                             dst_stall,
	output logic [bawc_pkg::DATA_W-1:0]      dst_word,
	output logic [bawc_pkg::DATA_W-1:0]      write_mask,
	output logic [bawc_pkg::IDX_W-1:0]       dst_index,
	output logic                             last_of_copy
);

	import bawc_pkg::*;

	localparam int FILL_W     = $clog2(WORD_BITS + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam logic [FILL_W-1:0] WORD_CNT  = FILL_W'(WORD_BITS);
	localparam logic [CNT_W-1:0]  PUSH_ROOM = CNT_W'(FIFO_DEPTH - 2);

	// mask of the n low bits
	function automatic logic [DATA_W-1:0] low_ones(input logic [FILL_W-1:0] n);
		logic [DATA_W-1:0] m;
		for (int i = 0; i < DATA_W; i++) begin
			m[i] = (i < int'(n));
		end
		return m;
	endfunction

	// offset modulo the word size, by repeated compare and subtract
	function automatic logic [FILL_W-1:0] off_mod(input logic [OFF_W-1:0] v);
		logic [OFF_W:0] r;
		r = {1'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (r >= (OFF_W+1)'(WORD_BITS)) begin
				r = r - (OFF_W+1)'(WORD_BITS);
			end
		end
		return FILL_W'(r);
	endfunction

	// configuration registers
	logic [WIDTH_W-1:0] copy_width_q;
	logic [OFF_W-1:0]   src_off_q;
	logic [OFF_W-1:0]   dst_off_q;
	logic               cfg_xfer;

	// copy state
	logic [DATA_W-1:0]  out_word_q;
	logic [FILL_W-1:0]  out_fill_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [WIDTH_W-1:0] bits_left_q;
	logic               first_q;

	// input register
	logic [DATA_W-1:0]  src_word_s1;
	logic               valid_s1;
	logic               go_s1;
	logic               src_xfer;

	// output queue
	result_t            fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	// step datapath
	logic               idle_skip;
	logic [FILL_W-1:0]  src_mod, dst_mod;
	logic [FILL_W-1:0]  skip, fill0, count, take, room, put, fill1, rem, fill2;
	logic [WIDTH_W-1:0] left0, left1, left2;
	logic [IDX_W-1:0]   idx0, idx2;
	logic [DATA_W-1:0]  word0, data, carry, placed, rest, word2;
	logic               full, done, emit_a, emit_b;
	result_t            res_a, res_b, res0;
	logic [1:0]         npush;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	// handshakes
	assign go_s1     = valid_s1 & (count_q <= PUSH_ROOM);
	assign src_stall = valid_s1 & ~go_s1;
	assign src_xfer  = src_valid & ~src_stall;
	assign dst_valid = (count_q != '0);
	assign pop       = dst_valid & ~dst_stall;

	// one source word against the copy state
	always_comb begin
		src_mod   = off_mod(src_off_q);
		dst_mod   = off_mod(dst_off_q);
		idle_skip = first_q & (copy_width_q == '0);
		skip      = first_q ? src_mod : '0;
		fill0     = first_q ? dst_mod : out_fill_q;
		left0     = first_q ? copy_width_q : bits_left_q;
		idx0      = first_q ? '0 : out_index_q;
		word0     = first_q ? '0 : out_word_q;

		data  = (src_word_s1 & low_ones(WORD_CNT)) >> skip;
		count = WORD_CNT - skip;
		take  = (WIDTH_W'(count) < left0) ? count : left0[FILL_W-1:0];
		carry = data & low_ones(take);

		room   = WORD_CNT - fill0;
		put    = (take < room) ? take : room;
		placed = word0 | ((carry & low_ones(put)) << fill0);
		fill1  = fill0 + put;
		rest   = carry >> put;
		rem    = take - put;
		left1  = left0 - WIDTH_W'(put);
		full   = (fill1 == WORD_CNT);

		// a finished word goes out first
		res_a.word  = placed;
		res_a.mask  = low_ones(WORD_CNT) & ~low_ones((idx0 == '0) ? dst_mod : '0);
		res_a.word  = placed & res_a.mask;
		res_a.index = idx0;
		res_a.last  = (left1 == '0);

		idx2  = full ? idx0 + 1'b1 : idx0;
		word2 = full ? '0 : placed;
		fill2 = full ? '0 : fill1;
		left2 = left1;
		// leftover source bits open the next word
		if (rem != '0) begin
			word2 = rest;
			fill2 = rem;
			left2 = left1 - WIDTH_W'(rem);
		end
		done = (left2 == '0);

		// flush of the trailing partial word
		res_b.mask  = low_ones(fill2) & ~low_ones((idx2 == '0) ? dst_mod : '0);
		res_b.word  = word2 & res_b.mask;
		res_b.index = idx2;
		res_b.last  = 1'b1;

		emit_a = ~idle_skip & full;
		emit_b = ~idle_skip & done & (fill2 != '0);
		res0   = emit_a ? res_a : res_b;
		npush  = {1'b0, emit_a} + {1'b0, emit_b};
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_width_q <= '0;
			src_off_q    <= '0;
			dst_off_q    <= '0;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				REG_COPY_WIDTH: copy_width_q <= cfg_data[WIDTH_W-1:0];
				REG_SRC_OFFSET: src_off_q    <= cfg_data[OFF_W-1:0];
				REG_DST_OFFSET: dst_off_q    <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// copy state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_word_q  <= '0;
			out_fill_q  <= '0;
			out_index_q <= '0;
			bits_left_q <= '0;
			first_q     <= 1'b1;
		end else if (cfg_xfer && cfg_index <= REG_DST_OFFSET) begin
			out_word_q  <= '0;
			out_fill_q  <= '0;
			out_index_q <= '0;
			bits_left_q <= '0;
			first_q     <= 1'b1;
		end else if (go_s1 && !idle_skip) begin
			if (done) begin
				out_word_q  <= '0;
				out_fill_q  <= '0;
				out_index_q <= '0;
				bits_left_q <= '0;
				first_q     <= 1'b1;
			end else begin
				out_word_q  <= word2;
				out_fill_q  <= fill2;
				out_index_q <= idx2;
				bits_left_q <= left2;
				first_q     <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_xfer) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_xfer) begin
			src_word_s1 <= src_word;
		end
	end

	// output queue storage, up to two entries written per cycle
	always_ff @(posedge clk) begin
		if (go_s1 && npush != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (go_s1 && npush == 2'd2) begin
			fifo_q[wr_ptr_q + 1'b1] <= res_b;
		end
	end

	// output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (go_s1) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(npush);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (go_s1 ? CNT_W'(npush) : '0) - CNT_W'(pop);
		end
	end

	// head of the queue drives the output
	assign dst_word     = fifo_q[rd_ptr_q].word;
	assign write_mask   = fifo_q[rd_ptr_q].mask;
	assign dst_index    = fifo_q[rd_ptr_q].index;
	assign last_of_copy = fifo_q[rd_ptr_q].last;

endmodule

// ===== sv/bawc_checker.sv =====
// bawc_checker: port level checks for the bit aligned word copy unit,
// bound into every instance of the unit
// depends on bawc_pkg
`timescale 1ns / 1ps

module bawc_checker #(
	parameter int WORD_BITS = bawc_pkg::WORD_BITS_DEFAULT
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             dst_valid,
	input logic                             dst_stall,
	input logic [bawc_pkg::DATA_W-1:0]      dst_word,
	input logic [bawc_pkg::DATA_W-1:0]      write_mask,
	input logic [bawc_pkg::IDX_W-1:0]       dst_index,
	input logic                             last_of_copy
);

	import bawc_pkg::*;

	// a held result keeps its payload
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_word) &&
		$stable(write_mask) && $stable(dst_index) && $stable(last_of_copy))
		else $error("destination payload changed while stalled");

	// data bits outside the write mask are zero
	a_masked_data: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (dst_word & ~write_mask) == '0)
		else $error("destination data outside write mask");

	// every word but the last is filled up to its top bit
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !last_of_copy |-> write_mask[WORD_BITS-1])
		else $error("non-final word not filled to the top");

	// after a word that is not the last, a word shown straight behind it carries the next index
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && !last_of_copy |=>
		!dst_valid || dst_index == $past(dst_index) + 1'b1)
		else $error("destination index did not advance by one");

endmodule

bind bit_aligned_word_copy_unit bawc_checker #(.WORD_BITS(WORD_BITS)) u_bawc_checker (.*);

// ===== bench/testbench.sv =====
// testbench: self-checking bench for bit_aligned_word_copy_unit, driving source words
// and register writes and checking every masked destination word against a local predictor
// depends on bawc_pkg and bit_aligned_word_copy_unit
`timescale 1ns / 1ps

module testbench;
	import bawc_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int WORD_BITS     = WORD_BITS_DEFAULT;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int QUIET_FROM    = 1500;
	localparam int PAUSE_EVERY   = 300;
	localparam int MAX_REPORTS   = 60;
	localparam int TIMEOUT_NS    = 2_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  src_valid;
	logic                  src_stall;
	logic [DATA_W-1:0]     src_word;
	logic                  dst_valid;
	logic                  dst_stall = 1'b0;
	logic [DATA_W-1:0]     dst_word;
	logic [DATA_W-1:0]     write_mask;
	logic [IDX_W-1:0]      dst_index;
	logic                  last_of_copy;

	// predictor registers and copy state
	logic [WIDTH_W-1:0]    cfg_copy_width;
	logic [OFF_W-1:0]      cfg_src_offset;
	logic [OFF_W-1:0]      cfg_dst_offset;
	logic [DATA_W-1:0]     spill_bits;
	int                    spill_cnt;
	longint                remaining_bits;
	logic [DATA_W-1:0]     build_word;
	int                    build_fill;
	logic [IDX_W-1:0]      build_index;
	logic                  at_copy_start;

	result_t               pending_dst_words[$];
	int                    fail_count   = 0;
	int                    items_sent   = 0;
	bit                    idle_enabled = 1'b1;
	int                    stall_left   = 0;

	bit_aligned_word_copy_unit #(
		.WORD_BITS(WORD_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_word    (src_word),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.dst_word    (dst_word),
		.write_mask  (write_mask),
		.dst_index   (dst_index),
		.last_of_copy(last_of_copy)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// mask of the n lowest bits
	function automatic logic [DATA_W-1:0] ones_below(input int n);
		if (n <= 0)
			return '0;
		if (n >= DATA_W)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < MAX_REPORTS)
			$display("%0d ns: %s got %h want %h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic clear_copy_state();
		spill_bits     = '0;
		spill_cnt      = 0;
		remaining_bits = 0;
		build_word     = '0;
		build_fill     = 0;
		build_index    = '0;
		at_copy_start  = 1'b1;
	endtask

	// queue the destination word being built, masked from its first written bit
	task automatic emit_dst_word(input logic last);
		result_t     r;
		int          start;
		logic [63:0] mask;
		start = (build_index == 0) ? (cfg_dst_offset % WORD_BITS) : 0;
		mask = ones_below(build_fill) & ~ones_below(start);
		r.word  = build_word & mask;
		r.mask  = mask;
		r.index = build_index;
		r.last  = last;
		pending_dst_words.push_back(r);
	endtask

	// expected destination words caused by one accepted source word
	task automatic predict_copy_step(input logic [DATA_W-1:0] w);
		int skip;
		int take;
		int room;
		int put;
		skip = 0;
		if (at_copy_start) begin
			if (cfg_copy_width == 0)
				return;
			remaining_bits = longint'(cfg_copy_width);
			build_word     = '0;
			build_fill     = cfg_dst_offset % WORD_BITS;
			build_index    = '0;
			at_copy_start  = 1'b0;
			skip           = cfg_src_offset % WORD_BITS;
		end

		// source bits that belong to the run
		spill_bits = (w & ones_below(WORD_BITS)) >> skip;
		spill_cnt  = WORD_BITS - skip;
		take = (spill_cnt < remaining_bits) ? spill_cnt : int'(remaining_bits);
		spill_bits &= ones_below(take);
		spill_cnt = take;

		// top up the current destination word
		room = WORD_BITS - build_fill;
		put = (spill_cnt < room) ? spill_cnt : room;
		build_word |= (spill_bits & ones_below(put)) << build_fill;
		build_fill += put;
		spill_bits = (put >= DATA_W) ? '0 : (spill_bits >> put);
		spill_cnt -= put;
		remaining_bits -= put;

		if (build_fill == WORD_BITS) begin
			emit_dst_word(remaining_bits == 0);
			build_index++;
			build_word = '0;
			build_fill = 0;
		end

		// leftover bits open the next destination word
		if (spill_cnt > 0) begin
			build_word = spill_bits;
			build_fill = spill_cnt;
			remaining_bits -= spill_cnt;
			spill_bits = '0;
			spill_cnt = 0;
		end

		if (remaining_bits == 0) begin
			if (build_fill > 0)
				emit_dst_word(1'b1);
			clear_copy_state();
		end
	endtask

	// receiver stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			dst_stall = 1'b1;
			stall_left--;
		end else begin
			dst_stall = 1'b0;
			if (idle_enabled && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 9);
		end
	end

	// compare each destination transfer with the oldest expected word
	always @(posedge clk) begin
		result_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			if (pending_dst_words.size() == 0) begin
				report_mismatch("unexpected result", dst_word, '0);
			end else begin
				want = pending_dst_words.pop_front();
				if (dst_word !== want.word)
					report_mismatch("dst_word", dst_word, want.word);
				if (write_mask !== want.mask)
					report_mismatch("write_mask", write_mask, want.mask);
				if (dst_index !== want.index)
					report_mismatch("dst_index", 64'(dst_index), 64'(want.index));
				if (last_of_copy !== want.last)
					report_mismatch("last_of_copy", 64'(last_of_copy), 64'(want.last));
			end
		end
	end

	task automatic src_idle(input int n);
		repeat (n) begin
			@(negedge clk);
			src_valid = 1'b0;
			src_word = {$urandom(), $urandom()};
		end
	endtask

	// one source word transfer, with an occasional gap ahead of it
	task automatic send_word(input logic [DATA_W-1:0] w);
		if (idle_enabled && $urandom_range(0, 5) == 0)
			src_idle($urandom_range(1, 9));
		@(negedge clk);
		src_valid = 1'b1;
		src_word = w;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		if (cfg_copy_width != 0)
			items_sent++;
		predict_copy_step(w);
	endtask

	// hold the source side until every expected word has left the block
	task automatic settle();
		if (src_valid) begin
			@(negedge clk);
			src_valid = 1'b0;
		end
		while (pending_dst_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_COPY_WIDTH: cfg_copy_width = data;
			REG_SRC_OFFSET: cfg_src_offset = data[OFF_W-1:0];
			REG_DST_OFFSET: cfg_dst_offset = data[OFF_W-1:0];
			default: ;
		endcase
		if (idx != REG_UNUSED)
			clear_copy_state();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// offset registers carry random upper bits that the block must drop
	task automatic program_copy(input logic [31:0] width, input logic [5:0] src_off,
			input logic [5:0] dst_off);
		logic [31:0] junk;
		junk = $urandom();
		cfg_write(REG_COPY_WIDTH, width);
		cfg_write(REG_SRC_OFFSET, {junk[31:6], src_off});
		junk = $urandom();
		cfg_write(REG_DST_OFFSET, {junk[31:6], dst_off});
	endtask

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return '1;
			1: return '0;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic send_words(input longint n);
		for (longint k = 0; k < n; k++)
			send_word(pick_word());
	endtask

	// width zero takes words and produces nothing
	task automatic test_zero_width();
		send_word('1);
		send_word('0);
		cfg_write(REG_COPY_WIDTH, '0);
		send_word({$urandom(), $urandom()});
	endtask

	// offset and width extremes, leading, middle and trailing pieces, surplus bits
	task automatic test_word_boundaries();
		program_copy(32'd64, 6'd0, 6'd0);
		send_word('1);
		program_copy(32'd1, 6'd63, 6'd63);
		send_word('1);
		program_copy(32'd1, 6'd0, 6'd0);
		send_word(64'h1);
		program_copy(32'd10, 6'd0, 6'd0);
		send_word('1);
		program_copy(32'd128, 6'd63, 6'd0);
		send_word('1);
		send_word('0);
		send_word(64'hA5A5_5A5A_C3C3_3C3C);
		program_copy(32'd200, 6'd5, 6'd37);
		send_words(4);
	endtask

	// widest copy, cut short by a register write
	task automatic test_long_copy_abort();
		program_copy(32'hFFFF_FFFF, 6'd17, 6'd50);
		send_words(4);
		cfg_write(REG_DST_OFFSET, 32'd0);
	endtask

	// a write to the unused index leaves a copy in progress alone
	task automatic test_unused_register();
		program_copy(32'd150, 6'd40, 6'd10);
		send_word(pick_word());
		cfg_write(REG_UNUSED, $urandom());
		send_words(2);
	endtask

	task automatic test_random_copies();
		logic [31:0] width;
		logic [5:0]  src_off;
		logic [5:0]  dst_off;
		longint      need;
		int          split;
		int          next_pause;
		next_pause = items_sent + PAUSE_EVERY;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= QUIET_FROM)
				idle_enabled = 1'b0;

			// mostly short runs, a few long ones and a rare huge one
			case ($urandom_range(0, 19))
				0:                  width = '0;
				1, 2, 3, 4, 5, 6:   width = $urandom_range(1, 64);
				7, 8, 9, 10, 11:    width = $urandom_range(65, 300);
				12, 13, 14, 15:     width = $urandom_range(1, 8);
				16, 17:             width = $urandom_range(301, 1500);
				18:                 width = $urandom() | 32'h0010_0000;
				default: begin
					case ($urandom_range(0, 3))
						0:       width = 32'hFFFF_FFFF;
						1:       width = 32'd64;
						2:       width = 32'd128;
						default: width = 32'd1;
					endcase
				end
			endcase
			case ($urandom_range(0, 7))
				0:       src_off = 6'd0;
				1:       src_off = 6'd63;
				default: src_off = $urandom();
			endcase
			case ($urandom_range(0, 7))
				0:       dst_off = 6'd0;
				1:       dst_off = 6'd63;
				default: dst_off = $urandom();
			endcase

			if ($urandom_range(0, 3) == 0)
				cfg_write(REG_COPY_WIDTH, width);
			else
				program_copy(width, src_off, dst_off);

			need = (longint'(cfg_copy_width) + cfg_src_offset + WORD_BITS - 1) / WORD_BITS;
			if (cfg_copy_width == 0) begin
				send_words($urandom_range(1, 2));
			end else if (need > 4096) begin
				send_words($urandom_range(1, 12));
			end else begin
				case ($urandom_range(0, 9))
					0: send_words($urandom_range(1, int'(need)));
					1: begin
						if (need > 1) begin
							split = $urandom_range(1, int'(need) - 1);
							send_words(split);
							cfg_write(REG_UNUSED, $urandom());
							send_words(need - split);
						end else begin
							send_words(need);
						end
					end
					default: send_words(need * $urandom_range(1, 3));
				endcase
			end

			// let the block drain completely now and then
			if (items_sent >= next_pause) begin
				settle();
				next_pause = items_sent + PAUSE_EVERY;
			end
		end
	endtask

	initial begin
		int drain_cycles;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		src_valid = 1'b0;
		src_word  = '0;
		cfg_copy_width = '0;
		cfg_src_offset = '0;
		cfg_dst_offset = '0;
		clear_copy_state();
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;

		test_zero_width();
		test_word_boundaries();
		test_long_copy_abort();
		test_unused_register();
		test_random_copies();

		// drain and give stragglers time to show up
		if (src_valid) begin
			@(negedge clk);
			src_valid = 1'b0;
		end
		drain_cycles = 0;
		while (pending_dst_words.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (pending_dst_words.size() != 0)
			report_mismatch("missing results", 64'(pending_dst_words.size()), '0);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
